>>> rtl/mld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mld_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned FIDX_W   = 6;
  localparam int unsigned DIST_W   = 30;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned ENTRY_W  = SAMPLE_W + 1;

  localparam logic [CFG_W-1:0] FEATURES_IN_USE_RESET = 7'd61;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic [ROW_W-1:0]           first_row;
    logic [FIDX_W-1:0]          feature_index;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       sample_present;
    logic [ROW_W-1:0]           second_row;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [ROW_W-1:0]  row_a;
    logic [ROW_W-1:0]  row_b;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_HOLD
  } state_t;

endpackage

`default_nettype wire

>>> rtl/masked_l1_distance_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Load transaction: written into the sample memory on acceptance; one per cycle while idle.
// Query transaction: min(features_in_use, FEATURES) feature pairs, one pair per cycle from
// two read ports; a zero count or a row out of range goes straight to the result.
// A new load or query is accepted only after the previous query's result reaches the output;
// a result still waiting on out_ready holds the next finished query and the input side.
// Reset (rst, synchronous): control clears and features_in_use returns to 61;
// the sample memory keeps its contents and is undefined until loaded.
module masked_l1_distance_engine #(
  parameter int ROWS     = 256,
  parameter int FEATURES = 64
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  mld_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output mld_pkg::out_t                       out_data,
  input  wire                                 cfg_we,
  input  wire  [mld_pkg::CFG_W-1:0]           cfg_data
);

  localparam int DEPTH  = ROWS * FEATURES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(FEATURES + 1);

  mld_pkg::state_t state, state_next;

  logic [mld_pkg::CFG_W-1:0]   features_in_use;
  logic [mld_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [mld_pkg::ENTRY_W-1:0] q_a, q_b;
  logic [ADDR_W-1:0]           base_a, base_b;
  logic [CNT_W-1:0]            f, count_r;
  logic [mld_pkg::ROW_W-1:0]   ra_r, rb_r;
  logic [mld_pkg::DIST_W-1:0]  sum;
  logic [mld_pkg::SAMPLE_W:0]  absd;
  logic                        rd_vld, abs_vld;

  logic                        accept, is_query, mem_we, issue, load_out, f_last, q_zero;
  logic [CNT_W-1:0]            count_in;
  logic [ADDR_W-1:0]           wr_addr, rd_addr_a, rd_addr_b;
  logic                        load_ok;
  logic                        both_present;
  logic signed [mld_pkg::SAMPLE_W-1:0] sa, sb;
  logic [mld_pkg::SAMPLE_W:0]  diff;

  assign accept   = in_valid && in_ready;
  assign is_query = (in_data.mode == mld_pkg::MODE_QUERY);

  assign count_in = (int'(features_in_use) > FEATURES) ? CNT_W'(FEATURES)
                                                       : CNT_W'(features_in_use);
  assign q_zero   = (count_in == '0) || (int'(in_data.first_row) >= ROWS)
                    || (int'(in_data.second_row) >= ROWS);
  assign f_last   = ((f + CNT_W'(1)) == count_r);

  assign load_ok  = (int'(in_data.first_row) < ROWS)
                    && (int'(in_data.feature_index) < FEATURES);
  assign mem_we   = accept && !is_query && load_ok;
  assign wr_addr  = ADDR_W'(in_data.first_row) * ADDR_W'(FEATURES)
                    + ADDR_W'(in_data.feature_index);
  assign rd_addr_a = base_a + ADDR_W'(f);
  assign rd_addr_b = base_b + ADDR_W'(f);

  always_comb begin
    state_next = state;
    case (state)
      mld_pkg::ST_IDLE: begin
        if (accept && is_query) begin
          state_next = q_zero ? mld_pkg::ST_HOLD : mld_pkg::ST_RUN;
        end
      end
      mld_pkg::ST_RUN: begin
        if (f_last) begin
          state_next = mld_pkg::ST_DRAIN;
        end
      end
      mld_pkg::ST_DRAIN: begin
        if (!rd_vld && !abs_vld) begin
          state_next = mld_pkg::ST_HOLD;
        end
      end
      mld_pkg::ST_HOLD: begin
        if (load_out) begin
          state_next = mld_pkg::ST_IDLE;
        end
      end
      default: state_next = mld_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state)
      mld_pkg::ST_IDLE:  in_ready = 1'b1;
      mld_pkg::ST_RUN:   issue    = 1'b1;
      mld_pkg::ST_DRAIN: issue    = 1'b0;
      mld_pkg::ST_HOLD:  load_out = !out_valid || out_ready;
      default:           issue    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= mld_pkg::ST_IDLE;
      features_in_use <= mld_pkg::FEATURES_IN_USE_RESET;
      rd_vld          <= 1'b0;
      abs_vld         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state   <= state_next;
      rd_vld  <= issue;
      abs_vld <= rd_vld;
      if (cfg_we) begin
        features_in_use <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sample memory: one write port, two read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {in_data.sample_present, in_data.sample_value};
    end
    q_a <= mem[rd_addr_a];
    q_b <= mem[rd_addr_b];
  end

  assign sa           = q_a[mld_pkg::SAMPLE_W-1:0];
  assign sb           = q_b[mld_pkg::SAMPLE_W-1:0];
  assign both_present = q_a[mld_pkg::SAMPLE_W] && q_b[mld_pkg::SAMPLE_W];
  assign diff = (sa >= sb)
      ? ({sa[mld_pkg::SAMPLE_W-1], sa} - {sb[mld_pkg::SAMPLE_W-1], sb})
      : ({sb[mld_pkg::SAMPLE_W-1], sb} - {sa[mld_pkg::SAMPLE_W-1], sa});

  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      base_a  <= ADDR_W'(in_data.first_row) * ADDR_W'(FEATURES);
      base_b  <= ADDR_W'(in_data.second_row) * ADDR_W'(FEATURES);
      count_r <= count_in;
      ra_r    <= in_data.first_row;
      rb_r    <= in_data.second_row;
      f       <= '0;
      sum     <= '0;
    end else begin
      if (issue) begin
        f <= f + CNT_W'(1);
      end
      if (abs_vld) begin
        sum <= sum + mld_pkg::DIST_W'(absd);
      end
    end
    absd <= both_present ? diff : '0;
    if (load_out) begin
      out_data.distance <= sum;
      out_data.row_a    <= ra_r;
      out_data.row_b    <= rb_r;
    end
  end

`ifndef SYNTHESIS
  a_rd_from_run: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state) == mld_pkg::ST_RUN)
    else $error("memory read data without a read issue");

  a_drained_at_hold: assert property (@(posedge clk) disable iff (rst)
    state == mld_pkg::ST_HOLD |-> !rd_vld && !abs_vld)
    else $error("result taken before accumulation drained");

  a_feature_bound: assert property (@(posedge clk) disable iff (rst)
    state == mld_pkg::ST_RUN |-> f < count_r)
    else $error("feature counter beyond feature count");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == mld_pkg::ST_IDLE && !rd_vld && !abs_vld)
    else $error("memory write during a query");

  a_out_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == mld_pkg::ST_HOLD)
    else $error("result valid without a finished query");
`endif

endmodule

`default_nettype wire
